// ===== hdl/csfdc_pkg.sv =====
// -----------------------------------------------------------------------------
// csfdc_pkg
// Shared types and constants for the CSF determinant coefficient block.
// -----------------------------------------------------------------------------
package csfdc_pkg;

  // Largest number of open-shell orbitals that one beat may describe.
  localparam int unsigned MaxOpen   = 16;
  // Fraction bits of the fixed-point coefficient.
  localparam int unsigned FracBits  = 30;

  localparam int unsigned OrbW      = $clog2(MaxOpen + 1);   // orbital counter
  localparam int unsigned SpinW     = $clog2(MaxOpen + 1) + 1; // signed s and m
  localparam int unsigned RatW      = $clog2(2 * MaxOpen + 5); // num and den
  localparam int unsigned QuoW      = 2 * FracBits + 1;      // quotient bits
  localparam int unsigned RadW      = 2 * FracBits + 2;      // radicand bits
  localparam int unsigned RootW     = FracBits + 1;          // root and magnitude
  localparam int unsigned RemW      = RootW + 4;             // square root remainder
  localparam int unsigned StepW     = $clog2(2 * FracBits + 1);
  localparam int unsigned CoefW     = 32;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] CfgOpenCount    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBosonicSigns = 1'd1;
  localparam int unsigned CfgDataW  = 5;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StWalk,
    StDiv,
    StSqrt,
    StMul,
    StDone
  } state_e;

endpackage

// ===== hdl/csf_determinant_coefficient.sv =====
// -----------------------------------------------------------------------------
// csf_determinant_coefficient
// Coefficient of one determinant in a genealogical spin-coupled CSF.
// -----------------------------------------------------------------------------
// Usage: an input beat on s_axis carries det_pattern (bits 15:0),
// coupling_pattern (bits 31:16) and absorb_sign (bit 32). One result beat on
// m_axis carries the signed coefficient (bits 31:0, 30 fraction bits) and
// illegal_coupling (bit 32). Registers open_count and bosonic_signs are set
// through the write port; the user must set them only while the block is
// idle, as the block itself does not enforce it. The block works on one beat
// at a time; s_axis_tready is high only while the sequencer is idle. Each
// walked orbital that still contributes passes through a setup step in the
// walk state, restoring division, restoring square root and a multiply; an
// orbital that contributes nothing takes only its walk step.
// Reset returns the sequencer to idle, clears the output valid flag and
// restores open_count to 1 and bosonic_signs to 0. When the receiver stalls,
// the finished result waits in the output register, and a new input beat is
// taken once the sequencer is idle; the next result waits for that register.
// -----------------------------------------------------------------------------
module csf_determinant_coefficient (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [csfdc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [csfdc_pkg::CfgDataW-1:0]      cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // det_pattern, coupling_pattern, absorb_sign, zeros
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // coefficient, illegal_coupling, zeros
);

  localparam int unsigned OrbW  = csfdc_pkg::OrbW;
  localparam int unsigned SpinW = csfdc_pkg::SpinW;
  localparam int unsigned RatW  = csfdc_pkg::RatW;
  localparam int unsigned QuoW  = csfdc_pkg::QuoW;
  localparam int unsigned RadW  = csfdc_pkg::RadW;
  localparam int unsigned RootW = csfdc_pkg::RootW;
  localparam int unsigned RemW  = csfdc_pkg::RemW;
  localparam int unsigned StepW = csfdc_pkg::StepW;
  localparam int unsigned CoefW = csfdc_pkg::CoefW;
  localparam int unsigned FracB = csfdc_pkg::FracBits;

  csfdc_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [4:0] open_count_q;
  logic       bosonic_q;

  // Item registers.
  logic [15:0] det_q, det_d;
  logic [15:0] coup_q, coup_d;
  logic        absorb_q, absorb_d;
  logic [OrbW-1:0] orb_q, orb_d;
  logic signed [SpinW-1:0] s_q, s_d, m_q, m_d;
  logic        neg_q, neg_d, illegal_q, illegal_d, zero_q, zero_d;
  logic        beta_par_q, beta_par_d, str_flip_q, str_flip_d;
  logic [RootW-1:0] mag_q, mag_d;

  // Shared divide and root unit.
  logic [RatW-1:0]  den_q, den_d;
  logic [RatW:0]    rdiv_q, rdiv_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [StepW-1:0] step_q, step_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [CoefW-1:0] out_coef_q, out_coef_d;
  logic             out_ill_q, out_ill_d;

  // Walk helpers.
  logic [OrbW-1:0]         n_orb;
  logic                    sp, mp;
  logic signed [SpinW-1:0] s_new, m_new, am;
  logic                    ill_new;
  logic [RatW-1:0]         num_w, den_w;

  // Unit helpers.
  logic [RatW:0]          rdiv_sh;
  logic [RemW-1:0]        rem_sh, trial;
  logic [2*RootW-1:0]     prod;
  logic [RootW-1:0]       mag_next;
  logic                   neg_final;
  logic signed [CoefW-1:0] coef_mag;
  logic                   out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // Orbital count saturates at the pattern width.
  assign n_orb = (open_count_q > 5'(csfdc_pkg::MaxOpen)) ?
                 OrbW'(csfdc_pkg::MaxOpen) : OrbW'(open_count_q);

  // Step of the partial spin and projection for the current orbital.
  always_comb begin
    sp      = coup_q[orb_q[3:0]];
    mp      = det_q[orb_q[3:0]];
    s_new   = sp ? s_q + SpinW'(1) : s_q - SpinW'(1);
    m_new   = mp ? m_q + SpinW'(1) : m_q - SpinW'(1);
    am      = m_new[SpinW-1] ? -m_new : m_new;
    ill_new = illegal_q || s_new[SpinW-1];
    if (sp) begin
      num_w = mp ? RatW'(s_new + m_new) : RatW'(s_new - m_new);
      den_w = RatW'(s_new <<< 1);
    end else begin
      num_w = mp ? RatW'(s_new + SpinW'(2) - m_new) : RatW'(s_new + SpinW'(2) + m_new);
      den_w = RatW'((s_new + SpinW'(2)) <<< 1);
    end
  end

  // Compare-subtract paths and the product.
  assign rdiv_sh  = {rdiv_q[RatW-1:0], 1'b0};
  assign rem_sh   = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial    = RemW'({root_q, 2'b01});
  assign prod     = {{RootW{1'b0}}, mag_q} * {{RootW{1'b0}}, root_q};
  assign mag_next = prod[FracB +: RootW];

  // Final sign and magnitude.
  assign neg_final = neg_q ^ (absorb_q && !bosonic_q && str_flip_q);
  assign coef_mag  = CoefW'(mag_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      csfdc_pkg::StIdle: if (s_axis_tvalid) state_d = csfdc_pkg::StWalk;
      csfdc_pkg::StWalk: begin
        if (orb_q == n_orb) begin
          state_d = csfdc_pkg::StDone;
        end else if (!ill_new && !zero_q && !(am > s_new)) begin
          state_d = csfdc_pkg::StDiv;
        end
      end
      csfdc_pkg::StDiv: if (step_q == StepW'(2 * FracB - 1)) state_d = csfdc_pkg::StSqrt;
      csfdc_pkg::StSqrt: if (step_q == StepW'(RootW - 1)) state_d = csfdc_pkg::StMul;
      csfdc_pkg::StMul: state_d = csfdc_pkg::StWalk;
      csfdc_pkg::StDone: if (out_free) state_d = csfdc_pkg::StIdle;
      default: state_d = csfdc_pkg::StIdle;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    s_axis_tready = (state_q == csfdc_pkg::StIdle);
    det_d = det_q;  coup_d = coup_q;  absorb_d = absorb_q;
    orb_d = orb_q;  s_d = s_q;  m_d = m_q;
    neg_d = neg_q;  illegal_d = illegal_q;  zero_d = zero_q;
    beta_par_d = beta_par_q;  str_flip_d = str_flip_q;  mag_d = mag_q;
    den_d = den_q;  rdiv_d = rdiv_q;  quo_d = quo_q;
    rad_d = rad_q;  rem_d = rem_q;  root_d = root_q;  step_d = step_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_coef_d  = out_coef_q;
    out_ill_d   = out_ill_q;
    case (state_q)
      csfdc_pkg::StIdle: begin
        det_d      = s_axis_tdata[15:0];
        coup_d     = s_axis_tdata[31:16];
        absorb_d   = s_axis_tdata[32];
        orb_d      = '0;
        s_d        = '0;
        m_d        = '0;
        neg_d      = 1'b0;
        illegal_d  = 1'b0;
        zero_d     = 1'b0;
        beta_par_d = 1'b0;
        str_flip_d = 1'b0;
        mag_d      = RootW'(1) << FracB;
      end
      csfdc_pkg::StWalk: begin
        if (orb_q != n_orb) begin
          orb_d     = orb_q + OrbW'(1);
          s_d       = s_new;
          m_d       = m_new;
          illegal_d = ill_new;
          // An alpha flips the string sign when an odd number of betas lie below.
          if (mp) begin
            str_flip_d = str_flip_q ^ beta_par_q;
          end else begin
            beta_par_d = !beta_par_q;
          end
          if (!ill_new && !zero_q) begin
            if (am > s_new) begin
              zero_d = 1'b1;
            end else begin
              if (!sp && mp) neg_d = !neg_q;
              den_d  = den_w;
              step_d = '0;
              quo_d  = '0;
              // The integer part of the ratio is one only when num equals den.
              if (num_w == den_w) begin
                quo_d[0] = 1'b1;
                rdiv_d   = '0;
              end else begin
                rdiv_d   = {1'b0, num_w};
              end
            end
          end
        end
      end
      csfdc_pkg::StDiv: begin
        // One restoring quotient bit per cycle.
        if (rdiv_sh >= {1'b0, den_q}) begin
          rdiv_d = rdiv_sh - {1'b0, den_q};
          quo_d  = {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rdiv_d = rdiv_sh;
          quo_d  = {quo_q[QuoW-2:0], 1'b0};
        end
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(2 * FracB - 1)) begin
          step_d = '0;
          rad_d  = {1'b0, quo_d};
          rem_d  = '0;
          root_d = '0;
        end
      end
      csfdc_pkg::StSqrt: begin
        // One restoring root bit per cycle, two radicand bits consumed.
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        rad_d  = {rad_q[RadW-3:0], 2'b00};
        step_d = step_q + StepW'(1);
      end
      csfdc_pkg::StMul: begin
        mag_d = mag_next;
        if (mag_next == '0) zero_d = 1'b1;
      end
      csfdc_pkg::StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ill_d   = illegal_q;
          if (illegal_q || zero_q) begin
            out_coef_d = '0;
          end else begin
            out_coef_d = neg_final ? -coef_mag : coef_mag;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= csfdc_pkg::StIdle;
      out_valid_q  <= 1'b0;
      open_count_q <= 5'd1;
      bosonic_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          csfdc_pkg::CfgOpenCount:    open_count_q <= cfg_data_i;
          csfdc_pkg::CfgBosonicSigns: bosonic_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    det_q <= det_d;  coup_q <= coup_d;  absorb_q <= absorb_d;
    orb_q <= orb_d;  s_q <= s_d;  m_q <= m_d;
    neg_q <= neg_d;  illegal_q <= illegal_d;  zero_q <= zero_d;
    beta_par_q <= beta_par_d;  str_flip_q <= str_flip_d;  mag_q <= mag_d;
    den_q <= den_d;  rdiv_q <= rdiv_d;  quo_q <= quo_d;
    rad_q <= rad_d;  rem_q <= rem_d;  root_q <= root_d;  step_q <= step_d;
    out_coef_q <= out_coef_d;
    out_ill_q  <= out_ill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_ill_q, out_coef_q};

endmodule

// ===== hdl/csfdc_checker.sv =====
// -----------------------------------------------------------------------------
// csfdc_checker
// Port-level checks for the CSF determinant coefficient block.
// -----------------------------------------------------------------------------
module csfdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // An illegal coupling always carries a zero coefficient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("illegal coupling with nonzero coefficient");

  // The coefficient magnitude never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= 32'sh4000_0000) &&
                      ($signed(m_axis_tdata[31:0]) >= -32'sh4000_0000))
    else $error("coefficient out of range");

  // One item at a time: an accepted beat closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind csf_determinant_coefficient csfdc_checker u_csfdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
